// File: rtl/core/kdar_pkg.sv
// Shared constants and codes for the key debounce and auto-repeat core.
`timescale 1ns / 1ps
package kdar_pkg;
    localparam int KEY_SLOTS = 32;
    localparam int KIDX_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int DIV_STEPS = 32;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [2:0] OP_KEY    = 3'd0;
    localparam logic [2:0] OP_TICK   = 3'd1;
    localparam logic [2:0] OP_STOP   = 3'd2;
    localparam logic [2:0] OP_RESTART = 3'd3;
    localparam logic [2:0] OP_RELALL = 3'd4;

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_REPEAT  = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    localparam logic [2:0] REG_DEBOUNCE = 3'd0;
    localparam logic [2:0] REG_DELAY    = 3'd1;
    localparam logic [2:0] REG_PERIOD   = 3'd2;
    localparam logic [2:0] REG_WHEEL_UP = 3'd3;
    localparam logic [2:0] REG_WHEEL_DN = 3'd4;
    localparam logic [2:0] REG_CAPS     = 3'd5;

    localparam logic [7:0] LVL_FULL = 8'hFF;
endpackage

// File: rtl/core/kdar_div.sv
// Bit-serial remainder unit: one restoring step per cycle.
`timescale 1ns / 1ps
module kdar_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [19:0] i_divisor,
    output logic        o_done,
    output logic [19:0] o_rem
);
    import kdar_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [31:0]       r_dvd;
    logic [19:0]       r_dvs;
    logic [19:0]       r_rem;
    logic [20:0]       trial;
    logic              ge;
    logic [20:0]       n_rem;

    assign trial = {r_rem, r_dvd[31]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign n_rem = ge ? (trial - {1'b0, r_dvs}) : trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= n_rem[19:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// File: rtl/core/key_debounce_and_autorepeat_core.sv
// Key debounce and typematic auto-repeat core, top level.
// A key event passes the states FL, UPD, FL and DONE; stop repeat and restart hold act as
// the item is accepted. Tick and release all walk every key slot: FL, UPD, FL for release all,
// FL and HOLD for tick, plus DIV and CHK where a slot needs a period remainder from the divider.
// One item at a time; the next is taken after the last result is registered.
// Synchronous active-low reset clears all key state and loads config defaults.
`timescale 1ns / 1ps
module key_debounce_and_autorepeat_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,  // key, pressed, level, event_time, now_time, elapsed, pad
    input  logic [2:0]    s_tuser,  // op
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata,  // key_out, level_out, stamp, caps_on, pad
    output logic [1:0]    m_tuser,  // event_kind
    output logic          m_tlast,  // last
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import kdar_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FL   = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_HOLD = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [2:0]        r_op;
    logic [KIDX_W-1:0] r_k;
    logic              r_ph, r_down, r_caps;
    logic [7:0]        r_lvl;
    logic [31:0]       r_ts, r_now, r_old, r_nw;
    logic [19:0]       r_el;

    logic [19:0] r_dbt, r_rp;
    logic [21:0] r_rd;
    logic [4:0]  r_wu, r_wd, r_cl;

    logic [KEY_SLOTS-1:0] r_raw, r_shown, r_off;
    logic [31:0] r_hold [KEY_SLOTS];
    logic [31:0] r_rct  [KEY_SLOTS];
    logic [31:0] r_rpt  [KEY_SLOTS];
    logic [31:0] r_sct  [KEY_SLOTS];

    logic        r_pv;
    logic [1:0]  r_pkind;
    logic [4:0]  r_pkey;
    logic [7:0]  r_plvl;
    logic [31:0] r_pstamp;

    logic        r_mv, r_mcaps, r_mlast;
    logic [1:0]  r_mkind;
    logic [4:0]  r_mkey;
    logic [7:0]  r_mlvl;
    logic [31:0] r_mstamp;

    logic [4:0]  in_key;
    logic        in_pressed;
    logic [7:0]  in_level;
    logic [31:0] in_ts, in_now;
    logic [19:0] in_el;
    logic        in_acc, in_range;
    logic [KIDX_W-1:0] in_k;

    logic [4:0]  cur_key;
    logic        last_k, out_free, can_emit, step;
    logic [31:0] fl_diff, old, nw, rd32;
    logic [32:0] sum33;
    logic        exempt, fl_go, hold_act, hold_gt, old_lt, chk_go;
    logic [19:0] per, d_rem;
    logic        d_done, d_start;
    logic        em;
    logic [1:0]  em_kind;
    logic [7:0]  em_lvl;
    logic [31:0] em_stamp;
    logic        push_mid, push_last, adv_more, wr_en;

    assign in_key     = s_tdata[4:0];
    assign in_pressed = s_tdata[5];
    assign in_level   = s_tdata[13:6];
    assign in_ts      = s_tdata[45:14];
    assign in_now     = s_tdata[77:46];
    assign in_el      = s_tdata[97:78];
    assign in_k       = KIDX_W'(in_key);
    assign in_range   = {1'b0, in_key} < 6'(KEY_SLOTS);
    assign s_tready   = (r_state == S_IDLE);
    assign in_acc     = s_tvalid && s_tready;

    assign cur_key  = 5'(r_k);
    assign last_k   = (r_k == KIDX_W'(KEY_SLOTS - 1));
    assign out_free = !r_mv || m_tready;
    assign can_emit = !r_pv || out_free;

    assign fl_diff = r_now - r_rpt[r_k];
    assign exempt  = (cur_key == r_wu) || (cur_key == r_wd);
    assign fl_go   = (r_raw[r_k] != r_shown[r_k]) && (exempt || fl_diff >= {12'b0, r_dbt});

    assign old      = r_hold[r_k];
    assign sum33    = {1'b0, old} + {13'b0, r_el};
    assign nw       = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
    assign rd32     = {10'b0, r_rd};
    assign per      = (r_rp == 20'd0) ? 20'd1 : r_rp;
    assign hold_act = r_shown[r_k] && !r_off[r_k];
    assign hold_gt  = nw > rd32;
    assign old_lt   = old < rd32;
    assign chk_go   = (r_nw - r_old) > {12'b0, d_rem};

    always_comb begin
        em       = 1'b0;
        em_kind  = KIND_REPEAT;
        em_lvl   = LVL_FULL;
        em_stamp = r_sct[r_k] + rd32;
        unique case (r_state)
            S_FL: begin
                em       = fl_go;
                em_kind  = r_raw[r_k] ? KIND_PRESS : KIND_RELEASE;
                em_lvl   = r_raw[r_k] ? r_lvl : 8'd0;
                em_stamp = r_rct[r_k];
            end
            S_HOLD: em = hold_act && hold_gt && old_lt;
            S_CHK: begin
                em       = chk_go;
                em_stamp = r_sct[r_k] + r_nw - {12'b0, d_rem};
            end
            default: em = 1'b0;
        endcase
    end

    assign step      = can_emit && ((r_state == S_FL) || (r_state == S_HOLD)
                                    || (r_state == S_CHK));
    assign push_mid  = step && em && r_pv;
    assign push_last = (r_state == S_DONE) && r_pv && out_free;
    assign adv_more  = ((r_op == OP_TICK) || (r_op == OP_RELALL)) && !last_k;
    assign d_start   = step && (r_state == S_HOLD) && hold_act && hold_gt && !old_lt;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (s_tuser)
                        OP_KEY:    n_state = in_range ? S_FL : S_IDLE;
                        OP_TICK:   n_state = S_FL;
                        OP_RELALL: n_state = S_FL;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_FL: begin
                if (step) begin
                    if (r_op == OP_TICK)   n_state = S_HOLD;
                    else if (!r_ph)        n_state = S_UPD;
                    else                   n_state = adv_more ? S_FL : S_DONE;
                end
            end
            S_UPD:  n_state = S_FL;
            S_HOLD: begin
                if (step) begin
                    if (d_start)       n_state = S_DIV;
                    else               n_state = adv_more ? S_FL : S_DONE;
                end
            end
            S_DIV:  n_state = d_done ? S_CHK : S_DIV;
            S_CHK:  if (step) n_state = adv_more ? S_FL : S_DONE;
            S_DONE: if (!r_pv || out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_caps  <= 1'b0;
            r_pv    <= 1'b0;
            r_mv    <= 1'b0;
            r_ph    <= 1'b0;
            r_op    <= OP_KEY;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_op <= s_tuser;
                r_ph <= 1'b0;
                r_k  <= ((s_tuser == OP_KEY) || (s_tuser == OP_STOP)
                         || (s_tuser == OP_RESTART)) ? in_k : '0;
                if (s_tuser == OP_KEY && in_range && in_key == r_cl && in_pressed)
                    r_caps <= !r_caps;
            end
            if (r_state == S_UPD) r_ph <= 1'b1;
            if ((step && n_state == S_FL && r_state != S_UPD)) begin
                r_k  <= r_k + 1'b1;
                r_ph <= 1'b0;
            end
            if (step && em)      r_pv <= 1'b1;
            else if (push_last)  r_pv <= 1'b0;
            if (push_mid || push_last) r_mv <= 1'b1;
            else if (m_tready)         r_mv <= 1'b0;
        end
    end

    // item payload and result registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_down <= (s_tuser == OP_KEY) ? in_pressed : 1'b0;
            r_lvl  <= (s_tuser == OP_TICK) ? LVL_FULL
                    : ((s_tuser == OP_KEY) ? in_level : 8'd0);
            r_ts   <= (s_tuser == OP_KEY) ? in_ts : in_now;
            r_now  <= in_now;
            r_el   <= in_el;
        end
        if (d_start) begin
            r_old <= old;
            r_nw  <= nw;
        end
        if (step && em) begin
            r_pkind  <= em_kind;
            r_pkey   <= cur_key;
            r_plvl   <= em_lvl;
            r_pstamp <= em_stamp;
        end
        if (push_mid || push_last) begin
            r_mkind  <= r_pkind;
            r_mkey   <= r_pkey;
            r_mlvl   <= r_plvl;
            r_mstamp <= r_pstamp;
            r_mcaps  <= r_caps;
            r_mlast  <= push_last;
        end
    end

    // per-key state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw   <= '0;
            r_shown <= '0;
            r_off   <= '0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_hold[i] <= '0;
                r_rct[i]  <= '0;
                r_rpt[i]  <= '0;
                r_sct[i]  <= '0;
            end
        end else begin
            if (in_acc && in_range) begin
                if (s_tuser == OP_STOP && r_shown[in_k]) r_off[in_k] <= 1'b1;
                if (s_tuser == OP_RESTART)               r_hold[in_k] <= '0;
            end
            if (step && r_state == S_FL && fl_go) begin
                r_rpt[r_k]   <= r_now;
                r_shown[r_k] <= r_raw[r_k];
                r_hold[r_k]  <= '0;
                r_sct[r_k]   <= r_rct[r_k];
                if (!r_raw[r_k]) r_off[r_k] <= 1'b0;
            end
            if (r_state == S_UPD && r_raw[r_k] != r_down) begin
                r_raw[r_k] <= r_down;
                r_rct[r_k] <= r_ts;
            end
            if (step && r_state == S_HOLD && hold_act) r_hold[r_k] <= nw;
        end
    end

    kdar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (d_start),
        .i_dividend (nw - rd32),
        .i_divisor  (per),
        .o_done     (d_done),
        .o_rem      (d_rem)
    );

    // configuration port
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbt <= 20'd0;
            r_rd  <= 22'd375000;
            r_rp  <= 20'd125000;
            r_wu  <= 5'd29;
            r_wd  <= 5'd30;
            r_cl  <= 5'd31;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_DEBOUNCE: r_dbt <= pwdata[19:0];
                REG_DELAY:    r_rd  <= pwdata[21:0];
                REG_PERIOD:   r_rp  <= pwdata[19:0];
                REG_WHEEL_UP: r_wu  <= pwdata[4:0];
                REG_WHEEL_DN: r_wd  <= pwdata[4:0];
                REG_CAPS:     r_cl  <= pwdata[4:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_DEBOUNCE: prdata = {12'b0, r_dbt};
            REG_DELAY:    prdata = {10'b0, r_rd};
            REG_PERIOD:   prdata = {12'b0, r_rp};
            REG_WHEEL_UP: prdata = {27'b0, r_wu};
            REG_WHEEL_DN: prdata = {27'b0, r_wd};
            REG_CAPS:     prdata = {27'b0, r_cl};
            default:      prdata = 32'd0;
        endcase
    end

    assign m_tvalid = r_mv;
    assign m_tdata  = {2'b0, r_mcaps, r_mstamp, r_mlvl, r_mkey};
    assign m_tuser  = r_mkind;
    assign m_tlast  = r_mlast;
endmodule

// File: rtl/core/kdar_chk.sv
// Port-level checker for the key debounce core, bound to the top level.
`timescale 1ns / 1ps
module kdar_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic [103:0]  s_tdata,
    input logic [2:0]    s_tuser,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [47:0]   m_tdata,
    input logic [1:0]    m_tuser,
    input logic          m_tlast,
    input logic          psel,
    input logic          penable,
    input logic          pwrite,
    input logic [4:0]    paddr,
    input logic [31:0]   pwdata,
    input logic [31:0]   prdata,
    input logic          pready
);
    import kdar_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_release_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == KIND_RELEASE |-> m_tdata[12:5] == 8'd0)
        else $error("release with nonzero level");

    a_repeat_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == KIND_REPEAT |-> m_tdata[12:5] == LVL_FULL)
        else $error("repeat without full level");
endmodule

bind key_debounce_and_autorepeat_core kdar_chk u_kdar_chk (.*);

// File: sim/kdar_checker.sv
// Checker for the key debounce core: predicts results from input transfers and compares them.
`timescale 1ns / 1ps
module kdar_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           o_fail_count,
    output int           o_pending
);
    import kdar_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  key;
        logic [7:0]  lvl;
        logic [31:0] stamp;
        logic        caps;
        logic        last;
    } t_key_evt;

    t_key_evt    evt_expect_q[$];
    t_key_evt    evt_step_q[$];

    bit [31:0] cfg_debounce, cfg_delay, cfg_period;
    bit [4:0]  cfg_wheel_up, cfg_wheel_dn, cfg_caps;

    bit        raw_down   [KEY_SLOTS];
    bit        shown_down [KEY_SLOTS];
    bit [31:0] hold_us    [KEY_SLOTS];
    bit [31:0] raw_t      [KEY_SLOTS];
    bit [31:0] report_t   [KEY_SLOTS];
    bit [31:0] shown_t    [KEY_SLOTS];
    bit [7:0]  lvl_mem    [KEY_SLOTS];
    bit        no_repeat  [KEY_SLOTS];
    bit        caps_state;
    int        fails;

    assign o_fail_count = fails;
    assign o_pending    = evt_expect_q.size();

    function automatic void add_evt(logic [1:0] kind, int k, bit [7:0] lvl, bit [31:0] stamp);
        t_key_evt e;
        if (evt_step_q.size() >= 64) return;
        e.kind = kind; e.key = k[4:0]; e.lvl = lvl; e.stamp = stamp;
        e.caps = 1'b0; e.last = 1'b0;
        evt_step_q.insert(evt_step_q.size(), e);
    endfunction

    function automatic void report_key(int k, bit [7:0] lvl, bit [31:0] now);
        if (raw_down[k] == shown_down[k]) return;
        if (k[4:0] != cfg_wheel_up && k[4:0] != cfg_wheel_dn)
            if (now - report_t[k] < cfg_debounce) return;
        report_t[k]   = now;
        shown_down[k] = raw_down[k];
        hold_us[k]    = 0;
        shown_t[k]    = raw_t[k];
        if (shown_down[k]) begin
            add_evt(KIND_PRESS, k, lvl, raw_t[k]);
        end else begin
            no_repeat[k] = 1'b0;
            add_evt(KIND_RELEASE, k, 8'd0, raw_t[k]);
        end
    endfunction

    function automatic void key_change(int k, bit down, bit [7:0] lvl, bit [31:0] ts,
                                       bit [31:0] now);
        report_key(k, lvl, now);
        if (raw_down[k] != down) begin
            raw_down[k] = down;
            raw_t[k]    = ts;
        end
        lvl_mem[k] = lvl;
        report_key(k, lvl, now);
    endfunction

    function automatic void tick_one(int k, bit [31:0] el, bit [31:0] now);
        bit [32:0] sum;
        bit [31:0] old, nw, per, rep;
        report_key(k, LVL_FULL, now);
        if (!shown_down[k] || no_repeat[k]) return;
        old = hold_us[k];
        sum = {1'b0, old} + {1'b0, el};
        nw  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        hold_us[k] = nw;
        if (nw <= cfg_delay) return;
        per = (cfg_period != 0) ? cfg_period : 32'd1;
        if (old < cfg_delay) begin
            rep = cfg_delay;
        end else begin
            if ((old - cfg_delay) / per == (nw - cfg_delay) / per) return;
            rep = cfg_delay + ((nw - cfg_delay) / per) * per;
        end
        add_evt(KIND_REPEAT, k, LVL_FULL, shown_t[k] + rep);
    endfunction

    function automatic void predict_item(logic [2:0] op, logic [103:0] d);
        bit [4:0]  k   = d[4:0];
        bit        dn  = d[5];
        bit [7:0]  lvl = d[13:6];
        bit [31:0] ts  = d[45:14];
        bit [31:0] now = d[77:46];
        bit [31:0] el  = {12'd0, d[97:78]};
        t_key_evt  e;
        evt_step_q.delete();
        case (op)
            OP_KEY: begin
                key_change(k, dn, lvl, ts, now);
                if (k == cfg_caps && dn) caps_state = !caps_state;
            end
            OP_TICK:    for (int i = 0; i < KEY_SLOTS; i++) tick_one(i, el, now);
            OP_STOP:    if (shown_down[k]) no_repeat[k] = 1'b1;
            OP_RESTART: hold_us[k] = 0;
            OP_RELALL:  for (int i = 0; i < KEY_SLOTS; i++) key_change(i, 1'b0, 8'd0, now, now);
            default: ;
        endcase
        for (int i = 0; i < evt_step_q.size(); i++) begin
            e = evt_step_q[i];
            e.caps = caps_state;
            e.last = (i == evt_step_q.size() - 1);
            evt_expect_q.insert(evt_expect_q.size(), e);
        end
    endfunction

    function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fails++;
        end
    endfunction

    initial fails = 0;

    always @(posedge i_clk) begin
        t_key_evt e;
        if (!i_rst_n) begin
            cfg_debounce = 0; cfg_delay = 375000; cfg_period = 125000;
            cfg_wheel_up = 29; cfg_wheel_dn = 30; cfg_caps = 31;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                raw_down[i] = 0; shown_down[i] = 0; hold_us[i] = 0; raw_t[i] = 0;
                report_t[i] = 0; shown_t[i] = 0; lvl_mem[i] = 0; no_repeat[i] = 0;
            end
            caps_state = 0;
            evt_expect_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (evt_expect_q.size() == 0) begin
                    $error("unexpected result transfer: key_out %0d", m_tdata[4:0]);
                    fails++;
                end else begin
                    e = evt_expect_q.pop_front();
                    cmp_field("event_kind", e.kind, m_tuser);
                    cmp_field("key_out", e.key, m_tdata[4:0]);
                    cmp_field("level_out", e.lvl, m_tdata[12:5]);
                    cmp_field("stamp", e.stamp, m_tdata[44:13]);
                    cmp_field("caps_on", e.caps, m_tdata[45]);
                    cmp_field("last", e.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata);
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_DEBOUNCE: cfg_debounce = {12'd0, pwdata[19:0]};
                    REG_DELAY:    cfg_delay    = {10'd0, pwdata[21:0]};
                    REG_PERIOD:   cfg_period   = {12'd0, pwdata[19:0]};
                    REG_WHEEL_UP: cfg_wheel_up = pwdata[4:0];
                    REG_WHEEL_DN: cfg_wheel_dn = pwdata[4:0];
                    REG_CAPS:     cfg_caps     = pwdata[4:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: sim/tb_top.sv
// Testbench top: drives key events, ticks and register writes into the core and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
    import kdar_pkg::*;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;   // key, pressed, level, event_time, now_time, elapsed, pad
    logic [2:0]   s_tuser = '0;   // op
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [47:0]  m_tdata;        // key_out, level_out, stamp, caps_on, pad
    logic [1:0]   m_tuser;        // event_kind
    logic         m_tlast;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count, pending;

    bit [31:0]    now_t;
    int           gap_max, adv_max, el_max;
    bit           long_hold_req;
    int           cycle_cnt = 0;

    key_debounce_and_autorepeat_core dut (.*);

    kdar_checker chk (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > 6000000) begin
            $display("FAILURE");
            $finish;
        end
    end

    // hold m_tready low for a drawn count after every transfer, and longer when long_hold_req is set
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 0;
                hold = 3000;
            end
            if (m_tvalid && m_tready)
                hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send(logic [2:0] op, bit [4:0] k, bit dn, bit [7:0] lvl, bit [31:0] ts,
                        bit [31:0] now, bit [19:0] el);
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, el, now, ts, lvl, dn, k};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic key_ev(bit [4:0] k, bit dn, bit [7:0] lvl);
        now_t += $urandom_range(0, adv_max);
        send(OP_KEY, k, dn, lvl, now_t - $urandom_range(0, 500), now_t, 20'($urandom));
    endtask

    task automatic tick(bit [19:0] el);
        now_t += el;
        send(OP_TICK, 5'($urandom), 1'($urandom), 8'($urandom), $urandom, now_t, el);
    endtask

    task automatic reg_write(logic [2:0] idx, bit [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (1500) @(posedge i_clk);
    endtask

    task automatic set_cfg(bit [31:0] db, bit [31:0] dl, bit [31:0] pr,
                           bit [4:0] wu, bit [4:0] wd, bit [4:0] cp);
        reg_write(REG_DEBOUNCE, db);
        reg_write(REG_DELAY, dl);
        reg_write(REG_PERIOD, pr);
        reg_write(REG_WHEEL_UP, wu);
        reg_write(REG_WHEEL_DN, wd);
        reg_write(REG_CAPS, cp);
    endtask

    task automatic random_items(int count);
        int r;
        bit [4:0] k;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            k = (r % 3 == 0) ? 5'($urandom) : 5'($urandom_range(0, 5)) + 26;
            if (n % 40 == 0) gap_max = ($urandom_range(0, 1) != 0) ? 0 : 17;
            if (r < 45) begin
                key_ev(k, 1'($urandom), 8'($urandom));
            end else if (r < 78) begin
                tick(($urandom_range(0, 19) == 0) ? 20'($urandom) : 20'($urandom_range(0, el_max)));
            end else if (r < 84) begin
                send(OP_STOP, k, 1'($urandom), 8'($urandom), $urandom, $urandom, 20'($urandom));
            end else if (r < 90) begin
                send(OP_RESTART, k, 1'($urandom), 8'($urandom), $urandom, $urandom, 20'($urandom));
            end else if (r < 94) begin
                now_t += $urandom_range(0, adv_max);
                send(OP_RELALL, k, 1'($urandom), 8'($urandom), $urandom, now_t, 20'($urandom));
            end else if (r < 97) begin
                send(3'($urandom_range(5, 7)), k, 1'($urandom), 8'($urandom), $urandom,
                     $urandom, 20'($urandom));
            end else begin
                send(OP_KEY, k, 1'($urandom), 8'($urandom), $urandom, $urandom, 20'($urandom));
            end
        end
    endtask

    initial begin
        long_hold_req = 0;
        gap_max = 17; adv_max = 2000; el_max = 200000;
        now_t = $urandom;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under default settings
        key_ev(0, 1, 8'hFF);
        key_ev(0, 0, 8'h00);
        send(OP_KEY, 31, 1, 8'h80, 32'hFFFF_FFFF, 32'h0000_0000, 20'h0);
        send(OP_KEY, 31, 0, 8'h01, 32'h0000_0000, 32'hFFFF_FFFF, 20'hFFFFF);
        key_ev(29, 1, 8'h55);
        key_ev(30, 1, 8'hAA);
        key_ev(5, 1, 8'h7F);
        tick(20'd0);
        tick(20'd375001);
        tick(20'd125000);
        send(OP_STOP, 5, 0, 0, 0, 0, 0);
        tick(20'hFFFFF);
        send(OP_RESTART, 29, 0, 0, 0, 0, 0);
        tick(20'd1000000);
        send(3'd5, 1, 1, 0, 0, 0, 0);
        send(3'd7, 2, 1, 0, 0, 0, 0);
        now_t += 10;
        send(OP_RELALL, 0, 0, 0, 0, now_t, 0);
        send(OP_STOP, 7, 0, 0, 0, 0, 0);
        key_ev(5, 1, 8'h10);
        drain();

        // no debounce, zero delay, zero period
        set_cfg(0, 0, 0, 3, 4, 5);
        el_max = 50; adv_max = 20;
        now_t = 32'hFFFF_FF00;
        random_items(90);
        // fill the core while the receiver holds off
        long_hold_req = 1;
        gap_max = 0;
        for (int i = 0; i < 6; i++) key_ev(5'(i), 1, 8'($urandom));
        for (int i = 0; i < 8; i++) tick(20'd7);
        drain();

        // large settings, close to the register maxima
        set_cfg(1000000, 4000000, 1000000, 31, 0, 0);
        gap_max = 17; el_max = 20'hFFFFF; adv_max = 1500000;
        random_items(90);
        drain();

        // short debounce, small delay and period
        set_cfg(300, 1000, 1, 26, 27, 28);
        el_max = 2000; adv_max = 600;
        random_items(90);
        drain();

        // mid settings, random wheel and caps keys
        set_cfg($urandom_range(0, 5000), $urandom_range(0, 40000), $urandom_range(1, 9000),
                5'($urandom), 5'($urandom), 5'($urandom));
        el_max = 20000; adv_max = 8000;
        random_items(90);
        drain();

        set_cfg(20, 500, 125, 29, 30, 31);
        el_max = 600; adv_max = 40;
        random_items(60);
        drain();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/kdar_pkg.sv
rtl/core/kdar_div.sv
rtl/core/key_debounce_and_autorepeat_core.sv
rtl/core/kdar_chk.sv
sim/kdar_checker.sv
sim/tb_top.sv
